// ===== rtl/core/mrpt_pkg.sv =====
package mrpt_pkg;

    typedef enum logic [2:0] {
        REG_BASE_COUNT = 3'd0,
        REG_BASE_ZERO  = 3'd1,
        REG_BASE_ONE   = 3'd2,
        REG_BASE_TWO   = 3'd3,
        REG_BASE_THREE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_MODRED = 2'd1,
        OP_MULMOD = 2'd2
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_R_A = 2'd0,
        SEL_A_A = 2'd1,
        SEL_R_R = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SPLIT,
        ST_RED,
        ST_RED_WAIT,
        ST_EXP,
        ST_EXP_MUL,
        ST_EXP_SQR,
        ST_CHECK,
        ST_SQR_LOOP,
        ST_SQR_WAIT,
        ST_NEXT,
        ST_OUT
    } mrpt_state_t;

    typedef struct packed {
        logic     start;
        dp_op_t   op;
        mul_sel_t sel;
        logic     to_r;
        logic     init_base;
        logic     shift_d;
        logic     shift_e;
        logic     inc_sq;
        logic     set_result;
        logic     result_value;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic n_le1;
        logic n_eq2;
        logic d_even;
        logic e_zero;
        logic e_lsb;
        logic r_eq1;
        logic r_eqnm1;
        logic sq_done;
    } dp_status_t;

endpackage

// ===== rtl/core/mrpt_datapath.sv =====
module mrpt_datapath
    import mrpt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] candidate,
    input  logic [WIDTH-1:0] base_raw,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic             is_probable_prime
);

    localparam int SW = $clog2(WIDTH + 1);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] n_reg, d_reg, e_reg, a_reg, r_reg;
    logic [SW-1:0]    s_reg, sq_reg;
    logic             res_reg;
    logic             busy_reg, busy_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] md_reg, x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             to_r_reg;
    logic             red_reg;
    logic [WIDTH-1:0] mod_reg;

    logic [WIDTH:0] dbl, add1, step;
    logic [WIDTH-1:0] bm2;

    assign bm2 = base_raw - WIDTH'(2);

    // shift-add: acc = (2*acc + msb(y)*x) mod m, one bit per cycle
    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, mod_reg})
            dbl = dbl - {1'b0, mod_reg};
        add1 = dbl + (y_reg[WIDTH-1] ? {1'b0, x_reg} : '0);
        if (add1 >= {1'b0, mod_reg})
            add1 = add1 - {1'b0, mod_reg};
        step = add1;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            acc_next = step[WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
        if (cmd.start)
        begin
            acc_next  = '0;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            res_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cmd.set_result)
                res_reg <= cmd.result_value;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        if (busy_reg && cnt_reg == CW'(1))
        begin
            if (red_reg)
                a_reg <= step[WIDTH-1:0] + WIDTH'(2);
            else if (to_r_reg)
                r_reg <= step[WIDTH-1:0];
            else
                a_reg <= step[WIDTH-1:0];
        end
        if (cmd.start)
        begin
            to_r_reg <= cmd.to_r;
            red_reg  <= (cmd.op == OP_MODRED);
            if (cmd.op == OP_MODRED)
            begin
                // (b-2) mod (n-2) reduced as (b-2) * 1 through the same unit
                mod_reg <= n_reg - WIDTH'(2);
                x_reg   <= WIDTH'(1);
                y_reg   <= bm2;
            end
            else
            begin
                mod_reg <= n_reg;
                case (cmd.sel)
                    SEL_R_A:
                    begin
                        x_reg <= r_reg;
                        y_reg <= a_reg;
                    end
                    SEL_A_A:
                    begin
                        x_reg <= a_reg;
                        y_reg <= a_reg;
                    end
                    default:
                    begin
                        x_reg <= r_reg;
                        y_reg <= r_reg;
                    end
                endcase
            end
        end
        else if (busy_reg)
            y_reg <= {y_reg[WIDTH-2:0], 1'b0};
        if (cmd.op == OP_LOAD && cmd.init_base)
        begin
            n_reg <= candidate;
            d_reg <= candidate - WIDTH'(1);
            s_reg <= '0;
        end
        else if (cmd.shift_d)
        begin
            d_reg <= d_reg >> 1;
            s_reg <= s_reg + SW'(1);
        end
        else if (cmd.init_base)
        begin
            e_reg  <= d_reg;
            r_reg  <= WIDTH'(1);
            sq_reg <= SW'(1);
        end
        if (cmd.shift_e)
            e_reg <= e_reg >> 1;
        if (cmd.inc_sq)
            sq_reg <= sq_reg + SW'(1);
    end

    always_comb
    begin
        status.busy    = busy_reg;
        status.n_le1   = (n_reg <= WIDTH'(1));
        status.n_eq2   = (n_reg == WIDTH'(2));
        status.d_even  = ~d_reg[0];
        status.e_zero  = (e_reg == '0);
        status.e_lsb   = e_reg[0];
        status.r_eq1   = (r_reg == WIDTH'(1));
        status.r_eqnm1 = (r_reg == n_reg - WIDTH'(1));
        status.sq_done = (sq_reg >= s_reg);
    end

    assign is_probable_prime = res_reg;

endmodule

// ===== rtl/core/mrpt_control.sv =====
module mrpt_control
    import mrpt_pkg::*;
#(
    parameter int MAX_BASES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] base_count,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic [1:0] base_sel
);

    mrpt_state_t state_reg, state_next;
    logic [2:0]  k_reg, k_next, count;

    assign count = (base_count == 3'd0) ? 3'd1 :
                   (base_count > 3'(MAX_BASES)) ? 3'(MAX_BASES) : base_count;
    assign base_sel = k_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.op     = OP_MULMOD;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op        = OP_LOAD;
                    cmd.init_base = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                k_next = '0;
                if (status.n_le1 || status.n_eq2)
                begin
                    cmd.set_result   = 1'b1;
                    cmd.result_value = status.n_eq2;
                    state_next       = ST_OUT;
                end
                else
                    state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (status.d_even)
                    cmd.shift_d = 1'b1;
                else
                begin
                    cmd.init_base = 1'b1;
                    state_next    = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MODRED;
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT:
                if (!status.busy)
                    state_next = ST_EXP;
            ST_EXP:
            begin
                if (status.e_zero)
                    state_next = ST_CHECK;
                else if (status.e_lsb)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_R_A;
                    cmd.to_r   = 1'b1;
                    state_next = ST_EXP_MUL;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_A_A;
                    state_next = ST_EXP_SQR;
                end
            end
            ST_EXP_MUL:
                if (!status.busy)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_A_A;
                    state_next = ST_EXP_SQR;
                end
            ST_EXP_SQR:
                if (!status.busy)
                begin
                    cmd.shift_e = 1'b1;
                    state_next  = ST_EXP;
                end
            ST_CHECK:
                state_next = (status.r_eq1 || status.r_eqnm1) ? ST_NEXT : ST_SQR_LOOP;
            ST_SQR_LOOP:
            begin
                if (status.sq_done)
                begin
                    cmd.set_result   = 1'b1;
                    cmd.result_value = 1'b0;
                    state_next       = ST_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_R_R;
                    cmd.to_r   = 1'b1;
                    cmd.inc_sq = 1'b1;
                    state_next = ST_SQR_WAIT;
                end
            end
            ST_SQR_WAIT:
                if (!status.busy)
                    state_next = status.r_eqnm1 ? ST_NEXT : ST_SQR_LOOP;
            ST_NEXT:
            begin
                if (k_reg + 3'd1 >= count)
                begin
                    cmd.set_result   = 1'b1;
                    cmd.result_value = 1'b1;
                    state_next       = ST_OUT;
                end
                else
                begin
                    k_next        = k_reg + 3'd1;
                    cmd.init_base = 1'b1;
                    state_next    = ST_RED;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < 3'(MAX_BASES))
        else $error("base index out of range");
`endif

endmodule

// ===== rtl/core/miller_rabin_primality_test.sv =====
// Miller-Rabin probable-prime test on an unsigned candidate, one transaction at a time.
// A controller drives one shared shift-add modular multiplier that retires one bit per
// cycle, for each product and for the base reduction. Each base costs at most about
// 2*WIDTH products; 0, 1 and 2 are resolved in ST_LOAD and go straight to ST_OUT. The input
// is stalled from acceptance until the result transaction is taken. Write configuration
// only while idle.
module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int MAX_BASES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_probable_prime,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [2:0]  base_count_reg;
    logic [31:0] bases_reg [4];
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [1:0]  base_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_count_reg <= 3'd3;
            bases_reg[0]   <= 32'd2;
            bases_reg[1]   <= 32'd7;
            bases_reg[2]   <= 32'd61;
            bases_reg[3]   <= 32'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_COUNT: base_count_reg <= cfg_data[2:0];
                REG_BASE_ZERO:  bases_reg[0]   <= cfg_data;
                REG_BASE_ONE:   bases_reg[1]   <= cfg_data;
                REG_BASE_TWO:   bases_reg[2]   <= cfg_data;
                REG_BASE_THREE: bases_reg[3]   <= cfg_data;
                default: ;
            endcase
        end
    end

    mrpt_control #(.MAX_BASES(MAX_BASES)) u_control (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .base_count (base_count_reg),
        .status     (status),
        .cmd        (cmd),
        .base_sel   (base_sel)
    );

    mrpt_datapath #(.WIDTH(WIDTH)) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .candidate         (candidate[WIDTH-1:0]),
        .base_raw          (bases_reg[base_sel][WIDTH-1:0]),
        .cmd               (cmd),
        .status            (status),
        .is_probable_prime (is_probable_prime)
    );

endmodule
